// ===== rtl/page_heap_allocator_top_macros.svh =====
// assertion macros for the page heap allocator
// no dependencies; included by the top level only
`ifndef PAGE_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_HEAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define PHA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page heap allocator check failed");
`define PHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page heap allocator check failed");
`else
`define PHA_ASSERT_NOW(lbl, ante, cons)
`define PHA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pha_pkg.sv =====
// shared types and codes of the page heap allocator
// no dependencies
package pha_pkg;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    // configuration register indexes
    localparam logic CFG_HEAP_START  = 1'b0;
    localparam logic CFG_LIMIT_PAGES = 1'b1;

    // register reset values
    localparam logic [31:0] HEAP_START_RST  = 32'h8000_0000;
    localparam logic [12:0] LIMIT_PAGES_RST = 13'd4096;

    typedef struct packed {
        logic        op;
        logic [24:0] request_bytes;
        logic [31:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_address;
        logic [24:0] byte_count;
    } t_out_item;

endpackage

// ===== rtl/pha_seg_ram.sv =====
// segment table storage: one write port, one registered read port
// no package dependencies
module pha_seg_ram #(
    parameter int DEPTH = 64,
    parameter int IX_W  = 6,
    parameter int DW    = 26
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IX_W-1:0] i_waddr,
    input  logic [DW-1:0]   i_wdata,
    input  logic [IX_W-1:0] i_raddr,
    output logic [DW-1:0]   o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/page_heap_allocator_top.sv =====
// page heap allocator: best fit over an address ordered segment table
// a free walks the table for the address; an allocate runs the merge and fit
// walk, then the split move
// throughput: one transaction at a time, bound by the one read per cycle
// of the segment memory; reset clears count, bump and used pages at once
// and needs no clearing pass
module page_heap_allocator_top
    import pha_pkg::*;
#(
    parameter int HEAP_PAGES   = 4096,
    parameter int MAX_SEGMENTS = 64,
    parameter int PAGE_SHIFT   = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    `include "page_heap_allocator_top_macros.svh"

    localparam int PG_W  = $clog2(HEAP_PAGES + 1);
    localparam int RQ_W  = 25 - PAGE_SHIFT + 1;
    localparam int MX_W  = (PG_W > RQ_W) ? ((PG_W > 13) ? PG_W : 13)
                                         : ((RQ_W > 13) ? RQ_W : 13);
    localparam int AW    = MX_W + 1;
    localparam int IX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int EW    = 2 * PG_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_FREE  = 4'd2;
    localparam logic [3:0] S_COAL  = 4'd3;
    localparam logic [3:0] S_TAIL  = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_SPLA  = 4'd7;
    localparam logic [3:0] S_SPLB  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    function automatic logic [31:0] addr_of(input logic [31:0] base,
                                            input logic [PG_W-1:0] pg);
        logic [PG_W+PAGE_SHIFT-1:0] sh;
        sh = {pg, {PAGE_SHIFT{1'b0}}};
        return base + 32'(sh);
    endfunction

    function automatic logic [24:0] bytes_of(input logic [AW-1:0] p);
        logic [AW+PAGE_SHIFT-1:0] t;
        t = {p, {PAGE_SHIFT{1'b0}}};
        return t[24:0];
    endfunction

    logic [3:0]       r_state, n_state;
    logic             r_op, n_op;
    logic [RQ_W-1:0]  r_pages, n_pages;
    logic [31:0]      r_faddr, n_faddr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PG_W-1:0]  r_bump, n_bump;
    logic [PG_W-1:0]  r_used, n_used;
    logic [31:0]      r_heap_start;
    logic [12:0]      r_limit;
    logic [IX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_pend, n_pend;
    logic [PG_W-1:0]  r_pstart, n_pstart;
    logic [IX_W-1:0]  r_pidx, n_pidx;
    logic             r_exact, n_exact;
    logic [IX_W-1:0]  r_eidx, n_eidx;
    logic [PG_W-1:0]  r_estart, n_estart;
    logic             r_best, n_best;
    logic [IX_W-1:0]  r_bidx, n_bidx;
    logic [PG_W-1:0]  r_bstart, n_bstart;
    logic [AW-1:0]    r_bsize, n_bsize;
    t_out_item        r_res, n_res;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             mem_we;
    logic [IX_W-1:0]  mem_waddr;
    logic [EW-1:0]    mem_wdata;
    logic [IX_W-1:0]  mem_raddr;
    logic [EW-1:0]    mem_rdata;
    logic [PG_W-1:0]  q_start;
    logic [PG_W-1:0]  q_pages;

    logic             do_eval;
    logic [PG_W-1:0]  ev_start;
    logic [IX_W-1:0]  ev_idx;
    logic [PG_W-1:0]  ev_end;
    logic [AW-1:0]    ev_fs;
    logic [AW-1:0]    pages_w;
    logic [AW-1:0]    cap;
    logic             last;
    logic             skip;
    logic             hit;
    logic             in_acc;
    logic             out_free;

    pha_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .IX_W  (IX_W),
        .DW    (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // handshake and helpers
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign q_start     = mem_rdata[EW-1:PG_W];
    assign q_pages     = mem_rdata[PG_W-1:0];
    assign pages_w     = AW'(r_pages);
    assign cap         = (AW'(r_limit) > AW'(HEAP_PAGES)) ? AW'(HEAP_PAGES) : AW'(r_limit);
    assign last        = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign skip        = (q_pages == '0) && (r_n != '0) && r_pend;
    assign hit         = (q_pages != '0) && (addr_of(r_heap_start, q_start) == r_faddr);
    assign ev_fs       = (ev_end > ev_start) ? AW'(ev_end - ev_start) : '0;

    // main sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_pages  = r_pages;
        n_faddr  = r_faddr;
        n_count  = r_count;
        n_bump   = r_bump;
        n_used   = r_used;
        n_idx    = r_idx;
        n_n      = r_n;
        n_pend   = r_pend;
        n_pstart = r_pstart;
        n_pidx   = r_pidx;
        n_exact  = r_exact;
        n_eidx   = r_eidx;
        n_estart = r_estart;
        n_best   = r_best;
        n_bidx   = r_bidx;
        n_bstart = r_bstart;
        n_bsize  = r_bsize;
        n_res    = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_raddr = r_idx + IX_W'(1);
        do_eval   = 1'b0;
        ev_start  = r_pstart;
        ev_idx    = r_pidx;
        ev_end    = q_start;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_in_data.op;
                    n_faddr = i_in_data.free_address;
                    n_pages = RQ_W'(i_in_data.request_bytes >> PAGE_SHIFT)
                            + RQ_W'(i_in_data.request_bytes[PAGE_SHIFT-1:0] != '0);
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                mem_raddr = '0;
                n_idx     = '0;
                n_n       = '0;
                n_pend    = 1'b0;
                n_exact   = 1'b0;
                n_best    = 1'b0;
                if (r_op == OP_FREE) begin
                    if (r_count == '0) begin
                        n_res   = '{ST_NOTFOUND, r_faddr, 25'd0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FREE;
                    end
                end else if (r_pages == '0) begin
                    n_res   = '{ST_ZERO, 32'd0, 25'd0};
                    n_state = S_DONE;
                end else if (AW'(r_used) + pages_w > cap) begin
                    n_res   = '{ST_NOSPACE, 32'd0, 25'd0};
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_COAL;
                end
            end
            S_FREE: begin
                n_idx = r_idx + IX_W'(1);
                if (hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = {q_start, {PG_W{1'b0}}};
                    n_used    = (r_used >= q_pages) ? r_used - q_pages : '0;
                    n_res     = '{ST_OK, r_faddr, bytes_of(AW'(q_pages))};
                    n_state   = S_DONE;
                end else if (last) begin
                    n_res   = '{ST_NOTFOUND, r_faddr, 25'd0};
                    n_state = S_DONE;
                end
            end
            S_COAL: begin
                // merge runs of free entries and weigh each free one for fit
                n_idx = r_idx + IX_W'(1);
                if (!skip) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_n[IX_W-1:0];
                    do_eval   = r_pend;
                    n_pend    = (q_pages == '0);
                    n_pstart  = q_start;
                    n_pidx    = r_n[IX_W-1:0];
                    n_n       = r_n + CNT_W'(1);
                end
                if (last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                // trailing free entry ends at the bump pointer
                do_eval = r_pend;
                ev_end  = r_bump;
                n_count = r_n;
                n_state = S_DEC;
            end
            S_DEC: begin
                mem_raddr = IX_W'(r_count - CNT_W'(1));
                if (r_exact) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_eidx;
                    mem_wdata = {r_estart, PG_W'(r_pages)};
                    n_used    = r_used + PG_W'(r_pages);
                    n_res     = '{ST_OK, addr_of(r_heap_start, r_estart), bytes_of(pages_w)};
                    n_state   = S_DONE;
                end else if (r_best) begin
                    if (r_count >= CNT_W'(MAX_SEGMENTS)) begin
                        n_res   = '{ST_FULL, 32'd0, 25'd0};
                        n_state = S_DONE;
                    end else if (CNT_W'(r_bidx) + CNT_W'(1) < r_count) begin
                        n_idx   = IX_W'(r_count - CNT_W'(1));
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_SPLA;
                    end
                end else if (AW'(r_bump) + pages_w > cap) begin
                    n_res   = '{ST_NOSPACE, 32'd0, 25'd0};
                    n_state = S_DONE;
                end else if (r_count >= CNT_W'(MAX_SEGMENTS)) begin
                    n_res   = '{ST_FULL, 32'd0, 25'd0};
                    n_state = S_DONE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = IX_W'(r_count);
                    mem_wdata = {r_bump, PG_W'(r_pages)};
                    n_count   = r_count + CNT_W'(1);
                    n_bump    = r_bump + PG_W'(r_pages);
                    n_used    = r_used + PG_W'(r_pages);
                    n_res     = '{ST_OK, addr_of(r_heap_start, r_bump), bytes_of(pages_w)};
                    n_state   = S_DONE;
                end
            end
            S_SHIFT: begin
                // move entries above the split point up by one
                mem_raddr = r_idx - IX_W'(1);
                mem_we    = 1'b1;
                mem_waddr = r_idx + IX_W'(1);
                n_idx     = r_idx - IX_W'(1);
                if (r_idx == r_bidx + IX_W'(1)) begin
                    n_state = S_SPLA;
                end
            end
            S_SPLA: begin
                mem_we    = 1'b1;
                mem_waddr = r_bidx;
                mem_wdata = {r_bstart, PG_W'(r_pages)};
                n_state   = S_SPLB;
            end
            S_SPLB: begin
                mem_we    = 1'b1;
                mem_waddr = r_bidx + IX_W'(1);
                mem_wdata = {r_bstart + PG_W'(r_pages), {PG_W{1'b0}}};
                n_count   = r_count + CNT_W'(1);
                n_used    = r_used + PG_W'(r_pages);
                n_res     = '{ST_OK, addr_of(r_heap_start, r_bstart), bytes_of(pages_w)};
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // exact fit wins, else smallest larger free segment, first on a tie
        if (do_eval && !r_exact) begin
            if (ev_fs == pages_w) begin
                n_exact  = 1'b1;
                n_eidx   = ev_idx;
                n_estart = ev_start;
            end else if (ev_fs > pages_w && (!r_best || ev_fs < r_bsize)) begin
                n_best   = 1'b1;
                n_bidx   = ev_idx;
                n_bstart = ev_start;
                n_bsize  = ev_fs;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_bump       <= '0;
            r_used       <= '0;
            r_heap_start <= HEAP_START_RST;
            r_limit      <= LIMIT_PAGES_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_bump  <= n_bump;
            r_used  <= n_used;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HEAP_START:  r_heap_start <= i_cfg_data;
                    CFG_LIMIT_PAGES: r_limit      <= i_cfg_data[12:0];
                    default:         r_limit      <= r_limit;
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pages  <= n_pages;
        r_faddr  <= n_faddr;
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_pend   <= n_pend;
        r_pstart <= n_pstart;
        r_pidx   <= n_pidx;
        r_exact  <= n_exact;
        r_eidx   <= n_eidx;
        r_estart <= n_estart;
        r_best   <= n_best;
        r_bidx   <= n_bidx;
        r_bstart <= n_bstart;
        r_bsize  <= n_bsize;
        r_res    <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    // checks
    `PHA_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_SEGMENTS))
    `PHA_ASSERT_NOW(a_used_le_bump, 1'b1, r_used <= r_bump)
    `PHA_ASSERT_NOW(a_shift_above_best, r_state == S_SHIFT, r_best && (r_idx > r_bidx))
    `PHA_ASSERT_NEXT(a_done_loads_out, r_state == S_DONE && out_free, o_out_valid)

endmodule

// ===== bench/page_heap_allocator_top_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for the page heap allocator: directed and random transactions
// against a built-in best fit predictor; depends on pha_pkg and page_heap_allocator_top
module page_heap_allocator_top_test;
    import pha_pkg::*;

    localparam int HEAP_PAGES   = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
    localparam int SETTLE       = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_HEAP_START;
    logic [31:0] i_cfg_data = '0;

    page_heap_allocator_top #(
        .HEAP_PAGES(HEAP_PAGES), .MAX_SEGMENTS(MAX_SEGMENTS), .PAGE_SHIFT(PAGE_SHIFT)
    ) dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [31:0] heap_base;
    int unsigned heap_limit;
    int unsigned seg_first[MAX_SEGMENTS];
    int unsigned seg_len[MAX_SEGMENTS];
    int unsigned seg_total;
    int unsigned bump_at;
    int unsigned pages_in_use;
    logic [31:0] live_blocks[$];

    t_in_item    request_queue[$];
    t_out_item   expected_replies[$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          took;

    function automatic logic [31:0] block_addr(int unsigned page);
        return heap_base + 32'(page << PAGE_SHIFT);
    endfunction

    function automatic t_out_item reply(logic [2:0] st, logic [31:0] addr, int unsigned pg);
        t_out_item r;
        r.status = st;
        r.result_address = addr;
        r.byte_count = 25'(pg << PAGE_SHIFT);
        return r;
    endfunction

    function automatic void rebuild_live();
        live_blocks.delete();
        for (int i = 0; i < seg_total; i++)
            if (seg_len[i] != 0) live_blocks.push_back(block_addr(seg_first[i]));
    endfunction

    function automatic int unsigned span_of(int unsigned i);
        int unsigned stop;
        stop = (i + 1 < seg_total) ? seg_first[i + 1] : bump_at;
        return stop > seg_first[i] ? stop - seg_first[i] : 0;
    endfunction

    // best fit allocator behaviour, one transaction in, one reply out
    function automatic t_out_item alloc_predict(t_in_item it);
        int unsigned pages, cap, n, best, best_span, fs, s;
        bit have_best;
        logic [31:0] a;
        if (it.op == OP_FREE) begin
            for (int i = 0; i < seg_total; i++) begin
                if (seg_len[i] != 0 && block_addr(seg_first[i]) == it.free_address) begin
                    pages = seg_len[i];
                    seg_len[i] = 0;
                    pages_in_use = pages_in_use >= pages ? pages_in_use - pages : 0;
                    foreach (live_blocks[k])
                        if (live_blocks[k] == it.free_address) begin
                            live_blocks.delete(k);
                            break;
                        end
                    return reply(ST_OK, it.free_address, pages);
                end
            end
            return reply(ST_NOTFOUND, it.free_address, 0);
        end
        pages = (it.request_bytes >> PAGE_SHIFT) + ((it.request_bytes % PAGE_BYTES) != 0);
        cap = heap_limit > HEAP_PAGES ? HEAP_PAGES : heap_limit;
        if (pages == 0) return reply(ST_ZERO, 0, 0);
        if (pages_in_use + pages > cap) return reply(ST_NOSPACE, 0, 0);
        // merge runs of free entries
        n = 0;
        for (int i = 0; i < seg_total; i++) begin
            if (seg_len[i] == 0 && n > 0 && seg_len[n - 1] == 0) continue;
            seg_first[n] = seg_first[i];
            seg_len[n] = seg_len[i];
            n++;
        end
        seg_total = n;
        have_best = 0;
        best = 0;
        best_span = 0;
        for (int i = 0; i < seg_total; i++) begin
            if (seg_len[i] == 0) begin
                fs = span_of(i);
                if (fs == pages) begin
                    seg_len[i] = pages;
                    pages_in_use += pages;
                    a = block_addr(seg_first[i]);
                    live_blocks.push_back(a);
                    return reply(ST_OK, a, pages);
                end
                if (fs > pages && (!have_best || fs < best_span)) begin
                    have_best = 1;
                    best = i;
                    best_span = fs;
                end
            end
        end
        if (have_best) begin
            s = seg_first[best];
            if (seg_total >= MAX_SEGMENTS) return reply(ST_FULL, 0, 0);
            for (int i = seg_total; i > best + 1; i--) begin
                seg_first[i] = seg_first[i - 1];
                seg_len[i] = seg_len[i - 1];
            end
            seg_len[best] = pages;
            seg_first[best + 1] = s + pages;
            seg_len[best + 1] = 0;
            seg_total++;
            pages_in_use += pages;
            a = block_addr(s);
            live_blocks.push_back(a);
            return reply(ST_OK, a, pages);
        end
        if (bump_at + pages > cap) return reply(ST_NOSPACE, 0, 0);
        if (seg_total >= MAX_SEGMENTS) return reply(ST_FULL, 0, 0);
        seg_first[seg_total] = bump_at;
        seg_len[seg_total] = pages;
        seg_total++;
        a = block_addr(bump_at);
        live_blocks.push_back(a);
        bump_at += pages;
        pages_in_use += pages;
        return reply(ST_OK, a, pages);
    endfunction

    // input driver with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                expected_replies.push_back(alloc_predict(i_in_data));
                void'(request_queue.pop_front());
                if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 11);
            end
            if (i_in_valid && !took) begin
                // hold the stalled transaction
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= request_queue[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output monitor and stall bursts
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual %p", $time, o_out_data);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.result_address !== want.result_address) begin
                    $display("%0t: address expected %h actual %h",
                             $time, want.result_address, o_out_data.result_address);
                    errors++;
                end
                if (o_out_data.byte_count !== want.byte_count) begin
                    $display("%0t: byte count expected %h actual %h",
                             $time, want.byte_count, o_out_data.byte_count);
                    errors++;
                end
            end
        end
        if (!i_rst_n || calm) begin
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11);
        end
        i_out_stall <= (stall_left > 0);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_START) heap_base = value;
        else heap_limit = value[12:0];
        rebuild_live();
    endtask

    task automatic drain();
        while (request_queue.size() > 0 || expected_replies.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_alloc(logic [24:0] bytes);
        t_in_item it;
        it.op = OP_ALLOC;
        it.request_bytes = bytes;
        it.free_address = $urandom;
        request_queue.push_back(it);
    endtask

    task automatic push_free(logic [31:0] addr);
        t_in_item it;
        it.op = OP_FREE;
        it.request_bytes = $urandom_range(0, 16777216);
        it.free_address = addr;
        request_queue.push_back(it);
    endtask

    // random transactions: mostly sensible sizes and frees of live blocks
    task automatic random_mix(int count, int max_pages, int free_pct);
        int unsigned pg;
        for (int k = 0; k < count; k++) begin
            while (request_queue.size() >= 2) @(posedge i_clk);
            if ($urandom_range(0, 99) < free_pct) begin
                if (live_blocks.size() > 0 && $urandom_range(0, 9) < 8)
                    push_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
                else if ($urandom_range(0, 1) == 0 && live_blocks.size() > 0)
                    push_free(live_blocks[0] + PAGE_BYTES);
                else
                    push_free($urandom);
            end else begin
                case ($urandom_range(0, 39))
                    0: push_alloc(25'd0);
                    1: push_alloc(25'($urandom_range(0, 16777216)));
                    default: begin
                        pg = $urandom_range(1, max_pages);
                        push_alloc(25'(pg * PAGE_BYTES -
                                       ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0)));
                    end
                endcase
            end
        end
        drain();
    endtask

    initial begin
        logic [31:0] hs;
        heap_base = HEAP_START_RST;
        heap_limit = LIMIT_PAGES_RST;
        seg_total = 0;
        bump_at = 0;
        pages_in_use = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // directed: sizes at the extremes, exact fit, split, merge, misses
        hs = 32'h0004_0000;
        write_reg(CFG_HEAP_START, hs);
        write_reg(CFG_LIMIT_PAGES, 13'd4096);
        push_alloc(25'd0);
        push_alloc(25'd1);
        push_alloc(25'd4096);
        push_alloc(25'd4097);
        push_free(hs + 32'h1000);
        push_free(hs);
        push_alloc(25'd8192);
        push_free(hs + 32'h2000);
        push_alloc(25'd4096);
        push_free(hs + 32'h2000);
        push_free(32'h1234_5678);
        push_free(32'hFFFF_FFFF);
        push_alloc(25'd16777216);
        push_alloc(25'd16777215);
        push_free(hs);
        push_free(hs + 32'h3000);
        push_alloc(25'd12288);
        push_alloc(25'h1FF_FFFF & 25'd16773121);
        drain();

        // free everything, then pack the table until it overflows
        write_reg(CFG_HEAP_START, 32'hFFFF_F000);
        while (live_blocks.size() > 0) begin
            push_free(live_blocks[0]);
            live_blocks.delete(0);
        end
        drain();
        rebuild_live();
        random_mix(250, 2, 8);

        write_reg(CFG_LIMIT_PAGES, 13'd1);
        random_mix(60, 3, 30);

        write_reg(CFG_HEAP_START, 32'h0000_0000);
        write_reg(CFG_LIMIT_PAGES, 13'h1FFF);
        random_mix(450, 40, 45);

        write_reg(CFG_HEAP_START, $urandom);
        write_reg(CFG_LIMIT_PAGES, 13'($urandom_range(1, 4096)));
        random_mix(400, 300, 50);

        calm = 1'b1;
        write_reg(CFG_HEAP_START, $urandom & 32'hFFFF_F000);
        write_reg(CFG_LIMIT_PAGES, 13'd4096);
        random_mix(380, 16, 45);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== page_heap_allocator_top.f =====
+incdir+rtl
rtl/pha_pkg.sv
rtl/pha_seg_ram.sv
rtl/page_heap_allocator_top.sv
bench/page_heap_allocator_top_test.sv
